@@ hdl/ggnt_pkg.sv @@
// Shared constants and types for the greedy geographic neighbour table.
`timescale 1ns / 1ps
package ggnt_pkg;

  localparam int MAX_NEIGHBORS = 16;
  localparam int ADDR_W        = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int CNT_W         = $clog2(MAX_NEIGHBORS + 1);

  localparam int ID_W    = 8;
  localparam int COORD_W = 16;
  localparam int HELLO_W = 16;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = SQ_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COORD_W;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_Y = 2'd1;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [HELLO_W-1:0]        hellos;
  } entry_t;

  // Slot travelling down the distance pipeline: own position or a stored entry.
  typedef struct packed {
    logic            vld;
    logic            own;
    logic [ID_W-1:0] id;
  } tag_t;

endpackage

@@ hdl/ggnt_if.sv @@
// Valid/ready channel interfaces for update/query items and result items.
`timescale 1ns / 1ps
interface ggnt_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [7:0]         neighbor_id;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;

  modport source (output valid, op, neighbor_id, pos_x, pos_y, input ready);
  modport sink   (input valid, op, neighbor_id, pos_x, pos_y, output ready);
endinterface

interface ggnt_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  next_hop;
  logic        hop_found;
  logic        new_neighbor;
  logic        table_full;
  logic [15:0] hello_count;

  modport source (output valid, next_hop, hop_found, new_neighbor, table_full,
                  hello_count, input ready);
  modport sink   (input valid, next_hop, hop_found, new_neighbor, table_full,
                  hello_count, output ready);
endinterface

@@ hdl/greedy_geo_neighbor_table_unit.sv @@
// Top level: neighbour table memory, scan sequencer and result register.
// Items are handled one at a time: a new item is taken only once the last one has left
// the finish step, after the one-read-per-cycle scan of the table memory and the
// three-stage distance pipeline have drained; an unread output register holds it there.
// A result waiting in the output register does not stop the next item being taken.
// Reset empties the table (entry count zero) and clears own_x and own_y to zero.
`timescale 1ns / 1ps
module greedy_geo_neighbor_table_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ggnt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ggnt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  ggnt_in_if.sink                             in_i,
  ggnt_out_if.source                          out_o
);
  import ggnt_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]                state_q, state_d;
  logic signed [COORD_W-1:0] own_x_q, own_y_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [CNT_W-1:0]          iss_q;
  logic [CNT_W-1:0]          iss_m1;

  logic                      item_op_q;
  logic [ID_W-1:0]           item_id_q;
  logic signed [COORD_W-1:0] item_x_q, item_y_q;

  entry_t                    mem [MAX_NEIGHBORS];
  entry_t                    rdata_q;
  entry_t                    wr_data;
  logic                      rd_en, wr_en;
  logic [ADDR_W-1:0]         rd_addr, wr_addr;

  logic                      p1_vld_q, p1_own_q;
  logic [ADDR_W-1:0]         p1_idx_q;
  tag_t                      tag;
  logic signed [COORD_W-1:0] ent_x, ent_y;
  logic                      dist_busy;
  logic [ID_W-1:0]           best_hop;
  logic                      best_found;

  logic                      match_q;
  logic [ADDR_W-1:0]         match_idx_q;
  logic [HELLO_W-1:0]        match_hel_q;
  logic [HELLO_W-1:0]        hel_inc;

  logic                      in_acc, out_load;
  logic                      out_vld_q;
  logic [ID_W-1:0]           out_hop_q;
  logic                      out_found_q, out_new_q, out_full_q;
  logic [HELLO_W-1:0]        out_hel_q;
  logic                      room;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign out_load   = (state_q == ST_FINISH) & (~out_vld_q | out_o.ready);
  assign room       = (cnt_q < CNT_W'(MAX_NEIGHBORS));

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_x_q <= '0;
      own_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OWN_X: own_x_q <= cfg_data_i;
        REG_OWN_Y: own_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_SCAN;
      ST_SCAN:   if (iss_q == cnt_q) state_d = ST_DRAIN;
      ST_DRAIN:  if (!p1_vld_q && !dist_busy) state_d = ST_FINISH;
      ST_FINISH: if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      iss_q    <= '0;
      p1_vld_q <= 1'b0;
      match_q  <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      p1_vld_q <= (state_q == ST_SCAN);
      if (in_acc) begin
        iss_q   <= '0;
        match_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        iss_q <= iss_q + 1'b1;
      end
      if (p1_vld_q && !p1_own_q && rdata_q.id == item_id_q) match_q <= 1'b1;
      if (out_load && item_op_q == OP_UPDATE && !match_q && room) cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_op_q <= in_i.op;
      item_id_q <= in_i.neighbor_id;
      item_x_q  <= in_i.pos_x;
      item_y_q  <= in_i.pos_y;
    end
    p1_own_q <= (iss_q == '0);
    p1_idx_q <= rd_addr;
    if (p1_vld_q && !p1_own_q && rdata_q.id == item_id_q) begin
      match_idx_q <= p1_idx_q;
      match_hel_q <= rdata_q.hellos;
    end
  end

  // Table memory: slot zero of a scan is own position, slot k reads entry k-1
  assign iss_m1  = iss_q - 1'b1;
  assign rd_addr = iss_m1[ADDR_W-1:0];
  assign rd_en   = (state_q == ST_SCAN) && (iss_q != '0);

  assign hel_inc        = (match_hel_q == '1) ? match_hel_q : match_hel_q + 1'b1;
  assign wr_en          = out_load && item_op_q == OP_UPDATE && (match_q || room);
  assign wr_addr        = match_q ? match_idx_q : cnt_q[ADDR_W-1:0];
  assign wr_data.id     = item_id_q;
  assign wr_data.x      = item_x_q;
  assign wr_data.y      = item_y_q;
  assign wr_data.hellos = match_q ? hel_inc : HELLO_W'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  assign tag.vld = p1_vld_q;
  assign tag.own = p1_own_q;
  assign tag.id  = rdata_q.id;
  assign ent_x   = p1_own_q ? own_x_q : rdata_q.x;
  assign ent_y   = p1_own_q ? own_y_q : rdata_q.y;

  ggnt_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (tag),
    .ent_x_i  (ent_x),
    .ent_y_i  (ent_y),
    .sink_x_i (item_x_q),
    .sink_y_i (item_y_q),
    .busy_o   (dist_busy),
    .hop_o    (best_hop),
    .found_o  (best_found)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (item_op_q == OP_QUERY) begin
        out_hop_q   <= best_found ? best_hop : '0;
        out_found_q <= best_found;
        out_new_q   <= 1'b0;
        out_full_q  <= 1'b0;
        out_hel_q   <= '0;
      end else begin
        out_hop_q   <= '0;
        out_found_q <= 1'b0;
        out_new_q   <= !match_q && room;
        out_full_q  <= !match_q && !room;
        out_hel_q   <= match_q ? hel_inc : (room ? HELLO_W'(1) : '0);
      end
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.next_hop     = out_hop_q;
  assign out_o.hop_found    = out_found_q;
  assign out_o.new_neighbor = out_new_q;
  assign out_o.table_full   = out_full_q;
  assign out_o.hello_count  = out_hel_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_NEIGHBORS))
    else $error("entry count beyond table depth");

  a_cnt_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> (out_vld_q && out_new_q))
    else $error("entry count moved without a new neighbour result");

  a_finish_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |-> (!p1_vld_q && !dist_busy))
    else $error("decision taken with scan still in flight");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == ST_FINISH))
    else $error("result raised outside the finish step");

endmodule

@@ hdl/ggnt_dist.sv @@
// Three-stage squared-distance pipeline with running best-neighbour selection.
`timescale 1ns / 1ps
module ggnt_dist (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ggnt_pkg::tag_t                     tag_i,
  input  logic signed [ggnt_pkg::COORD_W-1:0] ent_x_i,
  input  logic signed [ggnt_pkg::COORD_W-1:0] ent_y_i,
  input  logic signed [ggnt_pkg::COORD_W-1:0] sink_x_i,
  input  logic signed [ggnt_pkg::COORD_W-1:0] sink_y_i,
  output logic                               busy_o,
  output logic [ggnt_pkg::ID_W-1:0]          hop_o,
  output logic                               found_o
);
  import ggnt_pkg::*;

  logic signed [COORD_W:0] dx, dy, ndx, ndy;
  logic [COORD_W-1:0]      ax_d, ay_d;
  logic [COORD_W-1:0]      pa_ax_q, pa_ay_q;
  logic                    pa_vld_q, pa_own_q;
  logic [ID_W-1:0]         pa_id_q;
  logic [SQ_W-1:0]         sq_x_d, sq_y_d, pb_sqx_q, pb_sqy_q;
  logic                    pb_vld_q, pb_own_q;
  logic [ID_W-1:0]         pb_id_q;
  logic [DIST_W-1:0]       sum_sq;
  logic [DIST_W-1:0]       best_q;
  logic [ID_W-1:0]         hop_q;
  logic                    found_q;

  // Stage A: absolute coordinate differences
  always_comb begin
    dx   = {sink_x_i[COORD_W-1], sink_x_i} - {ent_x_i[COORD_W-1], ent_x_i};
    dy   = {sink_y_i[COORD_W-1], sink_y_i} - {ent_y_i[COORD_W-1], ent_y_i};
    ndx  = -dx;
    ndy  = -dy;
    ax_d = dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
    ay_d = dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
  end

  // Stage B: squares
  assign sq_x_d = {{COORD_W{1'b0}}, pa_ax_q} * {{COORD_W{1'b0}}, pa_ax_q};
  assign sq_y_d = {{COORD_W{1'b0}}, pa_ay_q} * {{COORD_W{1'b0}}, pa_ay_q};

  // Stage C: sum and compare
  assign sum_sq = {1'b0, pb_sqx_q} + {1'b0, pb_sqy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_vld_q <= 1'b0;
      pb_vld_q <= 1'b0;
    end else begin
      pa_vld_q <= tag_i.vld;
      pb_vld_q <= pa_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_ax_q  <= ax_d;
    pa_ay_q  <= ay_d;
    pa_own_q <= tag_i.own;
    pa_id_q  <= tag_i.id;
    pb_sqx_q <= sq_x_d;
    pb_sqy_q <= sq_y_d;
    pb_own_q <= pa_own_q;
    pb_id_q  <= pa_id_q;
    if (pb_vld_q) begin
      // own position arrives first and seeds the bar to beat
      if (pb_own_q) begin
        best_q  <= sum_sq;
        hop_q   <= '0;
        found_q <= 1'b0;
      end else if (sum_sq < best_q) begin
        best_q  <= sum_sq;
        hop_q   <= pb_id_q;
        found_q <= 1'b1;
      end
    end
  end

  assign busy_o  = pa_vld_q | pb_vld_q;
  assign hop_o   = hop_q;
  assign found_o = found_q;

endmodule

@@ test/tb_greedy_geo_neighbor_table_unit.sv @@
// Testbench for the greedy geographic neighbour table: directed table, random traffic, checking.
`timescale 1ns / 1ps
module tb_greedy_geo_neighbor_table_unit;
  import ggnt_pkg::*;

  localparam int STALL_PCT       = 25;
  localparam int CYCLE_LIMIT     = 2_500_000;
  localparam int N_PHASES        = 6;
  localparam int ITEMS_PER_PHASE = 187;
  localparam int CALM_PHASE      = 2;
  localparam int RAND_PHASE      = 4;
  localparam int SETTLE_CYCLES   = 2 * (MAX_NEIGHBORS + 7);
  localparam int PLAN_ROWS       = 21;

  // Indexes past own_y: the block must ignore writes to them.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic                      op;
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } route_req_t;

  typedef struct packed {
    logic [ID_W-1:0]    next_hop;
    logic               hop_found;
    logic               new_neighbor;
    logic               table_full;
    logic [HELLO_W-1:0] hello_count;
  } route_rsp_t;

  typedef struct {
    route_req_t req;
    int         reps;
    int         id_step;
    bit         typed;
    route_rsp_t rsp;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ggnt_in_if  route_req_if ();
  ggnt_out_if route_rsp_if ();

  greedy_geo_neighbor_table_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (route_req_if),
    .out_o      (route_rsp_if)
  );

  // Shadow of the neighbour table and node position
  entry_t                    nbr_tab [MAX_NEIGHBORS];
  int                        nbr_cnt = 0;
  logic signed [COORD_W-1:0] node_x  = '0;
  logic signed [COORD_W-1:0] node_y  = '0;

  route_rsp_t  expected_routes [$];
  bit          calm = 1'b0;
  int          err_count = 0;
  int          n_items = 0;
  int          n_found = 0;
  int          n_dropped = 0;
  int          n_settings = 0;
  int unsigned cycles = 0;

  plan_row_t dir_plan [PLAN_ROWS] = '{
    '{'{OP_QUERY,  8'h00, 16'sh0000, 16'sh0000}, 1, 0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 16'd0}},
    '{'{OP_UPDATE, 8'h00, 16'sh7FFF, 16'sh7FFF}, 1, 0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 16'd1}},
    '{'{OP_UPDATE, 8'h00, 16'sh7FFF, 16'sh8000}, 1, 0, 1'b1,
      '{8'h00, 1'b0, 1'b0, 1'b0, 16'd2}},
    '{'{OP_UPDATE, 8'h00, 16'sh7FFF, 16'sh7FFF}, 1, 0, 1'b1,
      '{8'h00, 1'b0, 1'b0, 1'b0, 16'd3}},
    '{'{OP_UPDATE, 8'hFF, 16'sh8000, 16'sh8000}, 1, 0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 16'd1}},
    '{'{OP_QUERY,  8'h00, 16'sh8000, 16'sh8000}, 1, 0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 16'd0}},
    '{'{OP_QUERY,  8'hFF, 16'sh7FFF, 16'sh7FFF}, 1, 0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 16'd0}},
    '{'{OP_QUERY,  8'h00, 16'sh0000, 16'sh0000}, 1, 0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 16'd0}},
    '{'{OP_UPDATE, 8'h5A, 16'sh8000, 16'sh7FFF}, 1, 0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 16'd1}},
    '{'{OP_UPDATE, 8'hA5, 16'sh7FFF, 16'sh8000}, 1, 0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 16'd1}},
    '{'{OP_UPDATE, 8'h11, 16'sd10,   16'sd90},   1, 0, 1'b0, '0},
    '{'{OP_UPDATE, 8'h22, -16'sd10,  16'sd90},   1, 0, 1'b0, '0},
    // equal distances: the earlier entry wins
    '{'{OP_QUERY,  8'h00, 16'sd0,    16'sd100},  1, 0, 1'b0, '0},
    '{'{OP_UPDATE, 8'h11, 16'sd0,    16'sd0},    1, 0, 1'b0, '0},
    '{'{OP_QUERY,  8'h00, 16'sd0,    16'sd100},  1, 0, 1'b0, '0},
    // fill the table with neighbours sharing one position
    '{'{OP_UPDATE, 8'h30, -16'sd1,   -16'sd1},   10, 1, 1'b0, '0},
    '{'{OP_UPDATE, 8'h40, 16'sd0,    16'sd0},    1, 0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 16'd0}},
    '{'{OP_UPDATE, 8'h39, 16'sd5,    16'sd5},    1, 0, 1'b0, '0},
    '{'{OP_QUERY,  8'h00, -16'sd2,   -16'sd2},   1, 0, 1'b0, '0},
    '{'{OP_QUERY,  8'h00, 16'sh8000, 16'sh7FFF}, 1, 0, 1'b1, '{8'h5A, 1'b1, 1'b0, 1'b0, 16'd0}},
    '{'{OP_UPDATE, 8'hFF, 16'sh8000, 16'sh8000}, 1, 0, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, expected_routes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint sq_dist(input logic signed [COORD_W-1:0] ax,
                                     input logic signed [COORD_W-1:0] ay,
                                     input logic signed [COORD_W-1:0] bx,
                                     input logic signed [COORD_W-1:0] by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return dx * dx + dy * dy;
  endfunction

  // Apply one item to the shadow table and return the result it should give.
  function automatic route_rsp_t predict_route(input route_req_t r);
    route_rsp_t res;
    longint     best;
    longint     d;
    bit         hit;
    res = '0;
    hit = 1'b0;
    if (r.op == OP_UPDATE) begin
      for (int i = 0; i < nbr_cnt; i++) begin
        if (!hit && nbr_tab[i].id == r.id) begin
          hit = 1'b1;
          nbr_tab[i].x = r.x;
          nbr_tab[i].y = r.y;
          if (nbr_tab[i].hellos != '1) nbr_tab[i].hellos = nbr_tab[i].hellos + 1'b1;
          res.hello_count = nbr_tab[i].hellos;
        end
      end
      if (!hit && nbr_cnt < MAX_NEIGHBORS) begin
        nbr_tab[nbr_cnt] = '{id: r.id, x: r.x, y: r.y, hellos: HELLO_W'(1)};
        nbr_cnt++;
        res.new_neighbor = 1'b1;
        res.hello_count  = HELLO_W'(1);
      end else if (!hit) begin
        res.table_full = 1'b1;
      end
    end else begin
      best = sq_dist(node_x, node_y, r.x, r.y);
      for (int i = 0; i < nbr_cnt; i++) begin
        d = sq_dist(nbr_tab[i].x, nbr_tab[i].y, r.x, r.y);
        if (d < best) begin
          best          = d;
          res.next_hop  = nbr_tab[i].id;
          res.hop_found = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // Mostly hellos from known neighbours and queries aimed near them; some unknown ids.
  function automatic route_req_t rand_route();
    route_req_t r;
    int         pick;
    int         k;
    r.id = ID_W'($urandom);
    r.x  = COORD_W'($urandom);
    r.y  = COORD_W'($urandom);
    pick = $urandom_range(99);
    k    = (nbr_cnt > 0) ? $urandom_range(nbr_cnt - 1) : 0;
    if (pick < 40) begin
      r.op = OP_UPDATE;
      if (nbr_cnt > 0) r.id = nbr_tab[k].id;
      if ($urandom_range(1)) begin
        r.x = node_x + COORD_W'($urandom_range(128)) - COORD_W'(64);
        r.y = node_y + COORD_W'($urandom_range(128)) - COORD_W'(64);
      end
    end else if (pick < 50) begin
      r.op = OP_UPDATE;
    end else begin
      r.op = OP_QUERY;
      if (pick < 75 && nbr_cnt > 0) begin
        r.x = nbr_tab[k].x + COORD_W'($urandom_range(64)) - COORD_W'(32);
        r.y = nbr_tab[k].y + COORD_W'($urandom_range(64)) - COORD_W'(32);
      end
    end
    return r;
  endfunction

  task automatic send_route(input route_req_t r, input bit typed, input route_rsp_t typed_rsp);
    route_rsp_t want;
    if (!calm) begin
      while ($urandom_range(99) < STALL_PCT) begin
        route_req_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    route_req_if.valid       <= 1'b1;
    route_req_if.op          <= r.op;
    route_req_if.neighbor_id <= r.id;
    route_req_if.pos_x       <= r.x;
    route_req_if.pos_y       <= r.y;
    do @(posedge clk); while (!route_req_if.ready);
    want = predict_route(r);
    n_items++;
    if (want.hop_found) n_found++;
    if (want.table_full) n_dropped++;
    expected_routes.insert(expected_routes.size(), typed ? typed_rsp : want);
  endtask

  // Hold off until every result is back and the block has gone quiet.
  task automatic drain_routes();
    route_req_if.valid <= 1'b0;
    while (expected_routes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_OWN_X: node_x = val;
      REG_OWN_Y: node_y = val;
      default: ;
    endcase
  endtask

  task automatic match_field(input string fname, input logic [HELLO_W-1:0] want,
                             input logic [HELLO_W-1:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    route_rsp_t want;
    if (route_rsp_if.valid && route_rsp_if.ready) begin
      if (expected_routes.size() == 0) begin
        err_count++;
        $display("%0t ns: result with no item outstanding, expected none, got hop %0h",
                 $time, route_rsp_if.next_hop);
      end else begin
        want = expected_routes[0];
        expected_routes.delete(0);
        match_field("next_hop",     HELLO_W'(want.next_hop),     HELLO_W'(route_rsp_if.next_hop));
        match_field("hop_found",    HELLO_W'(want.hop_found),    HELLO_W'(route_rsp_if.hop_found));
        match_field("new_neighbor", HELLO_W'(want.new_neighbor),
                    HELLO_W'(route_rsp_if.new_neighbor));
        match_field("table_full",   HELLO_W'(want.table_full),   HELLO_W'(route_rsp_if.table_full));
        match_field("hello_count",  want.hello_count,            route_rsp_if.hello_count);
      end
    end
    route_rsp_if.ready <= calm || ($urandom_range(99) >= STALL_PCT);
  end

  initial begin
    route_req_t                req;
    logic signed [COORD_W-1:0] set_x [N_PHASES];
    logic signed [COORD_W-1:0] set_y [N_PHASES];
    set_x = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh8000, 16'sh0000, 16'sh7FFF};
    set_y = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh7FFF, 16'sh0000, 16'sh8000};
    rst_n                    = 1'b0;
    cfg_we                   = 1'b0;
    cfg_idx                  = REG_OWN_X;
    cfg_data                 = '0;
    route_req_if.valid       = 1'b0;
    route_req_if.op          = OP_UPDATE;
    route_req_if.neighbor_id = '0;
    route_req_if.pos_x       = '0;
    route_req_if.pos_y       = '0;
    route_rsp_if.ready       = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows; repeated rows run without idling
    for (int i = 0; i < PLAN_ROWS; i++) begin
      calm = dir_plan[i].reps > 1;
      req  = dir_plan[i].req;
      for (int k = 0; k < dir_plan[i].reps; k++) begin
        send_route(req, dir_plan[i].typed, dir_plan[i].rsp);
        req.id = req.id + ID_W'(dir_plan[i].id_step);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_routes();
      if (ph == RAND_PHASE) begin
        set_x[ph] = COORD_W'($urandom);
        set_y[ph] = COORD_W'($urandom);
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
      end
      write_reg(REG_OWN_X, set_x[ph]);
      write_reg(REG_OWN_Y, set_y[ph]);
      n_settings++;
      calm = (ph == CALM_PHASE);
      repeat (ITEMS_PER_PHASE) send_route(rand_route(), 1'b0, '0);
    end
    drain_routes();

    $display("Ran %0d items over %0d own positions, table filled past capacity, ties checked.",
             n_items, n_settings + 1);
    $display("Next hop found %0d times; %0d new neighbours dropped on a full table.",
             n_found, n_dropped);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ greedy_geo_neighbor_table_unit.f @@
hdl/ggnt_pkg.sv
hdl/ggnt_if.sv
hdl/ggnt_dist.sv
hdl/greedy_geo_neighbor_table_unit.sv
test/tb_greedy_geo_neighbor_table_unit.sv
